// ===== src/tsd_pkg.sv =====
package tsd_pkg;

   // Archive geometry
   localparam int BLOCK_BYTES  = 512;
   localparam int OFFSET_BITS  = 9;
   localparam int LENGTH_BITS  = 40;
   localparam int SIZE_DIGITS  = 12;
   localparam int SIZE_BITS    = 3 * SIZE_DIGITS;
   localparam int SIZE_PORT_BITS = 64;
   localparam int MODE_BITS    = 24;

   // Header field positions
   localparam logic [OFFSET_BITS-1:0] MODE_FIRST = 9'd100;
   localparam logic [OFFSET_BITS-1:0] MODE_LAST  = 9'd107;
   localparam logic [OFFSET_BITS-1:0] SIZE_FIRST = 9'd124;
   localparam logic [OFFSET_BITS-1:0] SIZE_LAST  = 9'd135;
   localparam logic [OFFSET_BITS-1:0] TYPE_POS   = 9'd156;
   localparam logic [OFFSET_BITS-1:0] LAST_POS   = 9'(BLOCK_BYTES - 1);

   // Type bytes
   localparam logic [7:0] TYPE_FILE      = 8'h30;
   localparam logic [7:0] TYPE_NUL       = 8'h00;
   localparam logic [7:0] TYPE_LONG_NAME = 8'h4c;
   localparam logic [7:0] TYPE_LONG_LINK = 8'h4b;

   // Parser phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_FILE   = 3'd1;
   localparam logic [2:0] PH_LNAME  = 3'd2;
   localparam logic [2:0] PH_LLINK  = 3'd3;
   localparam logic [2:0] PH_PAD    = 3'd4;
   localparam logic [2:0] PH_TAIL   = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;
   localparam logic [2:0] PH_ERROR  = 3'd7;

   // Byte classes
   localparam logic [2:0] CLS_HEADER  = 3'd0;
   localparam logic [2:0] CLS_FILE    = 3'd1;
   localparam logic [2:0] CLS_LNAME   = 3'd2;
   localparam logic [2:0] CLS_LLINK   = 3'd3;
   localparam logic [2:0] CLS_PAD     = 3'd4;
   localparam logic [2:0] CLS_IGNORED = 3'd5;
   localparam logic [2:0] CLS_ERROR   = 3'd6;

   // Events
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_ENTRY      = 3'd1;
   localparam logic [2:0] EV_ZERO_END   = 3'd2;
   localparam logic [2:0] EV_SIZE_ERROR = 3'd3;
   localparam logic [2:0] EV_STREAM_END = 3'd4;

   typedef struct packed {
      logic [7:0]             byte_out;
      logic [2:0]             byte_class;
      logic [OFFSET_BITS-1:0] block_offset;
      logic [2:0]             event_res;
      logic [7:0]             entry_type;
      logic [SIZE_BITS-1:0]   entry_size;
      logic [MODE_BITS-1:0]   entry_mode;
      logic                   long_name_flag;
      logic                   long_link_flag;
   } result_type;

   function automatic logic is_octal(input logic [7:0] b);
      logic hit;
      hit = b inside {[8'h30:8'h37]};
      return hit;
   endfunction

endpackage

// ===== src/tsd_parse.sv =====
module tsd_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [7:0]                     data_byte,
   input  logic                           csr_wr_en,
   input  logic [tsd_pkg::LENGTH_BITS-1:0] csr_wr_data,
   output tsd_pkg::result_type            result
);

   logic [tsd_pkg::LENGTH_BITS-1:0] length_ff, length_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [tsd_pkg::OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [tsd_pkg::LENGTH_BITS-1:0] consumed_ff, consumed_in;
   logic                            all_zero_ff, all_zero_in;
   logic [tsd_pkg::SIZE_BITS-1:0]   size_acc_ff, size_acc_in;
   logic [tsd_pkg::MODE_BITS-1:0]   mode_acc_ff, mode_acc_in;
   logic [7:0]                      type_ff, type_in;
   logic [tsd_pkg::SIZE_BITS-1:0]   payload_ff, payload_in;
   logic                            pend_name_ff, pend_name_in;
   logic                            pend_link_ff, pend_link_in;

   logic [tsd_pkg::LENGTH_BITS-1:0] left_now;
   logic [tsd_pkg::LENGTH_BITS-1:0] rest;
   logic [tsd_pkg::SIZE_BITS-1:0]   payload_dec;
   logic [tsd_pkg::OFFSET_BITS-1:0] next_off;
   logic                            past_end;
   logic                            is_file;
   logic                            is_long;
   logic                            size_over;
   logic                            report;
   logic [2:0]                      cls;
   logic [2:0]                      ev;

   // Shared arithmetic on the stream position
   always_comb begin
      next_off    = offset_ff + 1'b1;
      left_now    = length_ff - consumed_ff;
      rest        = left_now - 1'b1;
      past_end    = consumed_ff >= length_ff;
      payload_dec = payload_ff - 1'b1;
      consumed_in = (&consumed_ff) ? consumed_ff : consumed_ff + 1'b1;
      length_in   = csr_wr_en ? csr_wr_data : length_ff;
   end

   // Per-byte step of the parser
   always_comb begin
      phase_in     = phase_ff;
      all_zero_in  = all_zero_ff;
      size_acc_in  = size_acc_ff;
      mode_acc_in  = mode_acc_ff;
      type_in      = type_ff;
      payload_in   = payload_ff;
      pend_name_in = pend_name_ff;
      pend_link_in = pend_link_ff;
      cls          = tsd_pkg::CLS_IGNORED;
      ev           = tsd_pkg::EV_NONE;
      report       = 1'b0;
      is_file      = 1'b0;
      is_long      = 1'b0;
      size_over    = 1'b0;

      if (phase_ff != tsd_pkg::PH_DONE && phase_ff != tsd_pkg::PH_ERROR && past_end) begin
         ev       = tsd_pkg::EV_STREAM_END;
         phase_in = tsd_pkg::PH_DONE;
      end else begin
         case (phase_ff)
            tsd_pkg::PH_HEADER: begin
               if (offset_ff == '0 &&
                   left_now[tsd_pkg::LENGTH_BITS-1:tsd_pkg::OFFSET_BITS] == '0) begin
                  // partial block at the end: skip it
                  phase_in = tsd_pkg::PH_TAIL;
               end else begin
                  if (offset_ff == '0) begin
                     all_zero_in = 1'b1;
                     size_acc_in = '0;
                     mode_acc_in = '0;
                     type_in     = '0;
                  end
                  cls = tsd_pkg::CLS_HEADER;
                  if (data_byte != 8'h00) begin
                     all_zero_in = 1'b0;
                  end
                  if (offset_ff >= tsd_pkg::MODE_FIRST && offset_ff <= tsd_pkg::MODE_LAST &&
                      tsd_pkg::is_octal(data_byte)) begin
                     mode_acc_in = {mode_acc_in[tsd_pkg::MODE_BITS-4:0], data_byte[2:0]};
                  end
                  if (offset_ff >= tsd_pkg::SIZE_FIRST && offset_ff <= tsd_pkg::SIZE_LAST &&
                      tsd_pkg::is_octal(data_byte)) begin
                     size_acc_in = {size_acc_in[tsd_pkg::SIZE_BITS-4:0], data_byte[2:0]};
                  end
                  if (offset_ff == tsd_pkg::TYPE_POS) begin
                     type_in = data_byte;
                  end
                  if (offset_ff == tsd_pkg::LAST_POS) begin
                     is_file   = type_in == tsd_pkg::TYPE_FILE || type_in == tsd_pkg::TYPE_NUL;
                     is_long   = type_in == tsd_pkg::TYPE_LONG_NAME ||
                                 type_in == tsd_pkg::TYPE_LONG_LINK;
                     size_over = {{(tsd_pkg::LENGTH_BITS-tsd_pkg::SIZE_BITS){1'b0}},
                                  size_acc_in} > rest;
                     if (all_zero_in) begin
                        ev       = tsd_pkg::EV_ZERO_END;
                        phase_in = tsd_pkg::PH_DONE;
                     end else if ((is_file || is_long) && size_over) begin
                        ev       = tsd_pkg::EV_SIZE_ERROR;
                        report   = 1'b1;
                        phase_in = tsd_pkg::PH_ERROR;
                     end else if (is_long) begin
                        if (type_in == tsd_pkg::TYPE_LONG_NAME) begin
                           pend_name_in = 1'b1;
                        end else begin
                           pend_link_in = 1'b1;
                        end
                        payload_in = size_acc_in;
                        if (size_acc_in != '0) begin
                           phase_in = (type_in == tsd_pkg::TYPE_LONG_NAME) ?
                                      tsd_pkg::PH_LNAME : tsd_pkg::PH_LLINK;
                        end
                     end else begin
                        ev           = tsd_pkg::EV_ENTRY;
                        report       = 1'b1;
                        pend_name_in = 1'b0;
                        pend_link_in = 1'b0;
                        if (is_file && size_acc_in != '0) begin
                           payload_in = size_acc_in;
                           phase_in   = tsd_pkg::PH_FILE;
                        end
                     end
                  end
               end
            end
            tsd_pkg::PH_FILE, tsd_pkg::PH_LNAME, tsd_pkg::PH_LLINK: begin
               // count down the payload, then pad to the block boundary
               case (phase_ff)
                  tsd_pkg::PH_FILE:  cls = tsd_pkg::CLS_FILE;
                  tsd_pkg::PH_LNAME: cls = tsd_pkg::CLS_LNAME;
                  default:           cls = tsd_pkg::CLS_LLINK;
               endcase
               payload_in = payload_dec;
               if (payload_dec == '0) begin
                  phase_in = (next_off == '0) ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
               end
            end
            tsd_pkg::PH_PAD: begin
               cls = tsd_pkg::CLS_PAD;
               if (next_off == '0) begin
                  phase_in = tsd_pkg::PH_HEADER;
               end
            end
            tsd_pkg::PH_ERROR: begin
               cls = tsd_pkg::CLS_ERROR;
            end
            default: begin
               cls = tsd_pkg::CLS_IGNORED;
            end
         endcase
      end
   end

   // Build the result item
   always_comb begin
      result.byte_out       = data_byte;
      result.byte_class     = cls;
      result.block_offset   = offset_ff;
      result.event_res      = ev;
      result.entry_type     = report ? type_in : '0;
      result.entry_size     = report ? size_acc_in : '0;
      result.entry_mode     = report ? mode_acc_in : '0;
      result.long_name_flag = report & pend_name_ff;
      result.long_link_flag = report & pend_link_ff;
   end

   // Hold parser state; advance only on a step (the length register loads on every write)
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         phase_ff     <= tsd_pkg::PH_HEADER;
         offset_ff    <= '0;
         consumed_ff  <= '0;
         all_zero_ff  <= 1'b1;
         size_acc_ff  <= '0;
         mode_acc_ff  <= '0;
         type_ff      <= '0;
         payload_ff   <= '0;
         pend_name_ff <= 1'b0;
         pend_link_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         if (step) begin
            phase_ff     <= phase_in;
            offset_ff    <= next_off;
            consumed_ff  <= consumed_in;
            all_zero_ff  <= all_zero_in;
            size_acc_ff  <= size_acc_in;
            mode_acc_ff  <= mode_acc_in;
            type_ff      <= type_in;
            payload_ff   <= payload_in;
            pend_name_ff <= pend_name_in;
            pend_link_ff <= pend_link_in;
         end
      end
   end

endmodule

// ===== src/tsd_out_reg.sv =====
module tsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tsd_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output tsd_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in;
   tsd_pkg::result_type data_ff, data_in;

   // Load a new item, or drop the current one once taken
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/tar_stream_deframer.sv =====
// Tar archive deframer: one archive byte in, one tagged byte out, at one item per clock
// when the result side keeps up. Each item passes an input register and then the parser,
// whose whole per-byte state update is combinational between that register and the
// result register, so a result shows on the ports once its item moves from the input
// register into the result register; it is taken at an edge where rsp_stall is low.
// The result register lets the next item be taken while a finished result still waits.
// The archive length register may be written only while the block is idle; it takes
// effect once registered. No clearing pass follows reset.
module tar_stream_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_byte_out,
   output logic [2:0]                      rsp_byte_class,
   output logic [8:0]                      rsp_block_offset,
   output logic [2:0]                      rsp_event_res,
   output logic [7:0]                      rsp_entry_type,
   output logic [63:0]                     rsp_entry_size,
   output logic [23:0]                     rsp_entry_mode,
   output logic                            rsp_long_name_flag,
   output logic                            rsp_long_link_flag,
   input  logic                            csr_wr_en,
   input  logic [39:0]                     csr_wr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                advance;
   logic                req_accept;
   tsd_pkg::result_type step_result;
   tsd_pkg::result_type out_data;

   // Move an item into the result register when it is free or being taken
   assign advance    = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Hold the input item until the parser takes it
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   tsd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (step_result)
   );

   tsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_data)
   );

   // Unpack the result item onto the ports
   assign rsp_byte_out       = out_data.byte_out;
   assign rsp_byte_class     = out_data.byte_class;
   assign rsp_block_offset   = out_data.block_offset;
   assign rsp_event_res      = out_data.event_res;
   assign rsp_entry_type     = out_data.entry_type;
   assign rsp_entry_size     = {{(tsd_pkg::SIZE_PORT_BITS-tsd_pkg::SIZE_BITS){1'b0}},
                                out_data.entry_size};
   assign rsp_entry_mode     = out_data.entry_mode;
   assign rsp_long_name_flag = out_data.long_name_flag;
   assign rsp_long_link_flag = out_data.long_link_flag;

   // Header-end events fall on the last byte of a block
   a_event_at_block_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == tsd_pkg::EV_ENTRY ||
                    rsp_event_res == tsd_pkg::EV_ZERO_END ||
                    rsp_event_res == tsd_pkg::EV_SIZE_ERROR)
      |-> rsp_block_offset == tsd_pkg::LAST_POS)
      else $error("header event away from block end");

   // The stream-end byte is always ignored
   a_stream_end_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == tsd_pkg::EV_STREAM_END
      |-> rsp_byte_class == tsd_pkg::CLS_IGNORED)
      else $error("stream end byte not ignored");

   // Entry fields stay zero unless an entry or a size error is reported
   a_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != tsd_pkg::EV_ENTRY &&
      rsp_event_res != tsd_pkg::EV_SIZE_ERROR
      |-> rsp_entry_size == '0 && rsp_entry_mode == '0 && rsp_entry_type == '0 &&
          !rsp_long_name_flag && !rsp_long_link_flag)
      else $error("entry fields set without an entry event");

   // A held input item is not lost while the result side stalls
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input item lost");

endmodule
